// ----- rtl/core/sadma_pkg.sv -----
// Shared types and constants for the sprite and sample DMA unit.
// No dependencies; every other file in rtl/core refers to this package by scoped names.
package sadma_pkg;

    localparam int unsigned IN_TDATA_W  = 56;
    localparam int unsigned IN_TUSER_W  = 1;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_TUSER_W = 2;
    localparam int unsigned COUNT_W     = 9;

    localparam logic [15:0] SPRITE_PORT_ADDR = 16'h2004;
    localparam logic [15:0] SPRITE_DMA_ADDR  = 16'h4014;
    localparam logic [15:0] JOY1_ADDR        = 16'h4016;
    localparam logic [15:0] JOY2_ADDR        = 16'h4017;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_DUMMY  = 2'd1,
        KIND_SPRITE = 2'd2,
        KIND_SAMPLE = 2'd3
    } read_kind_t;

    typedef struct packed {
        logic        get_cycle;
        logic        cpu_access;
        logic        cpu_write;
        logic [15:0] cpu_address;
        logic [7:0]  cpu_write_data;
        logic        sample_request;
        logic        sample_abort_only;
        logic [15:0] sample_address;
        logic [7:0]  fetched_byte;
    } item_t;

    typedef struct packed {
        logic         cpu_ready;
        read_kind_t   read_kind;
        logic [15:0]  read_address;
        logic         sprite_write_valid;
        logic [7:0]   sprite_write_data;
        logic         sample_accepted;
        logic         dma_busy;
    } result_t;

    typedef struct packed {
        logic               sprite_pending;
        logic               sprite_active;
        logic               sprite_write_due;
        logic [7:0]         sprite_page;
        logic [7:0]         sprite_offset;
        logic [COUNT_W-1:0] sprite_count;
        logic               sample_active;
        logic               sample_abort;
        logic [15:0]        sample_addr_held;
        logic               sample_dummy_due;
        logic               halt_wanted;
        logic               cpu_halted;
        logic [15:0]        halted_address;
    } dma_state_t;

    // Handshake status passed from the pipeline control to the stages.
    typedef struct packed {
        logic advance;
    } pipe_ctrl_t;

endpackage

// ----- rtl/core/sadma_in_stage.sv -----
// Input register of the sprite and sample DMA unit: holds one accepted transaction.
// Depends on sadma_pkg for the item type and the bus width.
module sadma_in_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sadma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic [sadma_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  sadma_pkg::pipe_ctrl_t               ctrl,
    output logic                                item_valid,
    output sadma_pkg::item_t                    item
);

    logic             in_valid_reg;
    logic             in_valid_next;
    sadma_pkg::item_t in_item_reg;
    sadma_pkg::item_t in_item_next;
    logic             take;

    // The register empties whenever its item moves on, so a new item may enter the same cycle.
    assign s_axis_tready = !in_valid_reg || ctrl.advance;
    assign take          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (ctrl.advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        in_item_next                   = in_item_reg;
        if (take)
        begin
            in_item_next.get_cycle         = s_axis_tuser[0];
            in_item_next.cpu_access        = s_axis_tdata[0];
            in_item_next.cpu_write         = s_axis_tdata[1];
            in_item_next.cpu_address       = s_axis_tdata[17:2];
            in_item_next.cpu_write_data    = s_axis_tdata[25:18];
            in_item_next.sample_request    = s_axis_tdata[26];
            in_item_next.sample_abort_only = s_axis_tdata[27];
            in_item_next.sample_address    = s_axis_tdata[43:28];
            in_item_next.fetched_byte      = s_axis_tdata[51:44];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    assign item_valid = in_valid_reg;
    assign item       = in_item_reg;

endmodule

// ----- rtl/core/sadma_step.sv -----
// One CPU-cycle step of the DMA unit: next state and result from the current state and item.
// Depends on sadma_pkg for the state, item and result types and the fixed addresses.
module sadma_step
#(
    parameter int unsigned SPRITE_BYTES = 256
)
(
    input  sadma_pkg::dma_state_t state,
    input  sadma_pkg::item_t      item,
    output sadma_pkg::dma_state_t state_next,
    output sadma_pkg::result_t    result
);

    localparam logic [sadma_pkg::COUNT_W-1:0] COUNT_END = sadma_pkg::COUNT_W'(SPRITE_BYTES);

    always_comb
    begin
        sadma_pkg::dma_state_t s;
        sadma_pkg::result_t    r;
        logic                  cpu_wrote;
        logic                  sample_ready;
        logic                  dummy_ok;

        s            = state;
        r            = '0;
        r.read_kind  = sadma_pkg::KIND_NONE;
        cpu_wrote    = item.cpu_access && item.cpu_write;
        sample_ready = state.sample_active && !state.halt_wanted && !state.sample_dummy_due;
        // Dummy reads of the controller ports would clock their shift registers.
        dummy_ok     = (state.halted_address != sadma_pkg::JOY1_ADDR) &&
                       (state.halted_address != sadma_pkg::JOY2_ADDR);

        if (!state.cpu_halted)
        begin
            if (cpu_wrote && item.cpu_address == sadma_pkg::SPRITE_DMA_ADDR)
            begin
                s.sprite_page    = item.cpu_write_data;
                s.sprite_offset  = '0;
                s.sprite_pending = 1'b1;
            end
            if (state.halt_wanted)
            begin
                if (cpu_wrote)
                begin
                    // A write cycle cannot be halted; an abort-only request gives up here.
                    if (state.sample_active && state.sample_abort)
                    begin
                        s.sample_active    = 1'b0;
                        s.sample_abort     = 1'b0;
                        s.sample_dummy_due = 1'b0;
                        if (!state.sprite_active)
                        begin
                            s.halt_wanted = 1'b0;
                        end
                    end
                end
                else
                begin
                    s.cpu_halted     = 1'b1;
                    s.halted_address = item.cpu_address;
                    s.halt_wanted    = 1'b0;
                    if (state.sample_abort)
                    begin
                        s.sample_active = 1'b0;
                        s.sample_abort  = 1'b0;
                        if (!state.sprite_active)
                        begin
                            s.cpu_halted = 1'b0;
                        end
                    end
                end
            end
        end
        else
        begin
            if (item.get_cycle)
            begin
                if (sample_ready)
                begin
                    r.read_kind     = sadma_pkg::KIND_SAMPLE;
                    r.read_address  = state.sample_addr_held;
                    s.sample_active = 1'b0;
                    s.sample_abort  = 1'b0;
                end
                else if (state.sprite_active && !state.sprite_write_due)
                begin
                    r.read_kind        = sadma_pkg::KIND_SPRITE;
                    r.read_address     = {state.sprite_page, state.sprite_offset};
                    s.sprite_write_due = 1'b1;
                end
                else if (dummy_ok)
                begin
                    r.read_kind    = sadma_pkg::KIND_DUMMY;
                    r.read_address = state.halted_address;
                end
            end
            else if (state.sprite_active && state.sprite_write_due)
            begin
                r.sprite_write_valid = 1'b1;
                r.sprite_write_data  = item.fetched_byte;
                s.sprite_write_due   = 1'b0;
                s.sprite_offset      = state.sprite_offset + 8'd1;
                s.sprite_count       = state.sprite_count + 1'b1;
                if (s.sprite_count == COUNT_END)
                begin
                    s.sprite_active = 1'b0;
                end
            end
            else if (dummy_ok)
            begin
                r.read_kind    = sadma_pkg::KIND_DUMMY;
                r.read_address = state.halted_address;
            end

            if (state.halt_wanted)
            begin
                s.halt_wanted = 1'b0;
            end
            else if (state.sample_dummy_due)
            begin
                s.sample_dummy_due = 1'b0;
            end

            if (!s.sprite_active && !s.sample_active)
            begin
                s.cpu_halted = 1'b0;
            end
        end

        // New requests are registered after the cycle's work.
        if (s.sprite_pending)
        begin
            if (!s.sprite_active)
            begin
                s.sprite_active    = 1'b1;
                s.sprite_write_due = 1'b0;
                s.sprite_count     = '0;
                s.sprite_offset    = '0;
                s.halt_wanted      = 1'b1;
            end
            s.sprite_pending = 1'b0;
        end
        if (!s.sample_active && item.sample_request)
        begin
            s.sample_active    = 1'b1;
            s.sample_abort     = item.sample_abort_only;
            s.sample_addr_held = item.sample_address;
            s.halt_wanted      = 1'b1;
            s.sample_dummy_due = !item.sample_abort_only;
            r.sample_accepted  = 1'b1;
        end

        r.cpu_ready = !(s.cpu_halted || s.halt_wanted);
        r.dma_busy  = s.sprite_pending || s.sprite_active || s.sample_active ||
                      s.cpu_halted || s.halt_wanted;

        state_next = s;
        result     = r;
    end

endmodule

// ----- rtl/core/sadma_out_stage.sv -----
// Result register of the sprite and sample DMA unit and its master-side stream port.
// Depends on sadma_pkg for the result type and the bus widths.
module sadma_out_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  sadma_pkg::pipe_ctrl_t               ctrl,
    input  sadma_pkg::result_t                  result,
    input  logic                                m_axis_tready,
    output logic                                m_axis_tvalid,
    output logic [sadma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [sadma_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    output logic                                out_free
);

    logic               out_valid_reg;
    logic               out_valid_next;
    sadma_pkg::result_t out_data_reg;
    sadma_pkg::result_t out_data_next;

    // Free when empty or when the held result leaves this cycle.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (ctrl.advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_data_reg.read_kind;
    assign m_axis_tdata  = {4'b0000,
                            out_data_reg.dma_busy,
                            out_data_reg.sample_accepted,
                            out_data_reg.sprite_write_data,
                            out_data_reg.sprite_write_valid,
                            out_data_reg.read_address,
                            out_data_reg.cpu_ready};

endmodule

// ----- rtl/core/sprite_and_sample_dma_unit.sv -----
// Top level of the sprite and sample DMA unit: handshake control, DMA state registers, stages.
// Depends on sadma_pkg, sadma_in_stage, sadma_step and sadma_out_stage.
//
// Usage. Each slave-side transaction is one CPU cycle: the CPU bus access, the sample
// channel request and the byte returned by the DMA read issued for the previous cycle.
// Each transaction yields exactly one master-side transaction that carries the ready level
// for the next CPU cycle, the DMA read (kind and address), the sprite port write, whether
// the sample request was taken, and a busy flag. A write to 0x4014 arms a sprite copy of
// SPRITE_BYTES bytes; a sample request arms a one-byte fetch or only a halt attempt.
//
// A transaction accepted into the input register is stepped once the result register has room:
// the step logic then writes the result register and the DMA state together, and the result
// is offered on the master side from the result register.
// Throughput is one transaction per cycle while the receiver does not stall, set by the single
// step between the input and result registers, which also closes the state loop.
//
// Reset clears the DMA state and both stage valid flags; the unit then takes items at once.
// When the receiver stalls, the held result stays on the master side and stepping stops;
// an empty input register still takes one more transaction, and then tready stays low
// until the result register frees.
module sprite_and_sample_dma_unit
#(
    parameter int unsigned SPRITE_BYTES = 256
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0: cpu_access, cpu_write, cpu_address[15:0], cpu_write_data[7:0],
    // sample_request, sample_abort_only, sample_address[15:0], fetched_byte[7:0], zero pad.
    input  logic [sadma_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // Fields from bit 0: get_cycle.
    input  logic [sadma_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0: cpu_ready, read_address[15:0], sprite_write_valid,
    // sprite_write_data[7:0], sample_accepted, dma_busy, zero pad.
    output logic [sadma_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0: read_kind[1:0].
    output logic [sadma_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

    sadma_pkg::pipe_ctrl_t ctrl;
    logic                  item_valid;
    logic                  out_free;
    sadma_pkg::item_t      item;
    sadma_pkg::dma_state_t state_reg;
    sadma_pkg::dma_state_t state_next;
    sadma_pkg::dma_state_t step_state;
    sadma_pkg::result_t    step_result;

    // An item is stepped when it sits in the input register and the result register has room.
    assign ctrl.advance  = item_valid && out_free;

    sadma_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .ctrl          (ctrl),
        .item_valid    (item_valid),
        .item          (item)
    );

    sadma_step
    #(
        .SPRITE_BYTES (SPRITE_BYTES)
    )
    u_step
    (
        .state      (state_reg),
        .item       (item),
        .state_next (step_state),
        .result     (step_result)
    );

    // The DMA state moves only when a CPU cycle is stepped.
    assign state_next = ctrl.advance ? step_state : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    sadma_out_stage u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .result        (step_result),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .out_free      (out_free)
    );

    // The DMA state holds whenever no CPU cycle is stepped.
    a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.advance |=> $stable(state_reg))
        else $error("DMA state changed without a stepped cycle");

    // A cycle stepped while the CPU runs issues no DMA read and no sprite write.
    a_no_dma_unhalted : assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.advance && !state_reg.cpu_halted) |=>
            (m_axis_tuser == sadma_pkg::KIND_NONE && !m_axis_tdata[17]))
        else $error("DMA bus activity while the CPU was not halted");

    // The byte count never passes the copy length.
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sprite_count <= sadma_pkg::COUNT_W'(SPRITE_BYTES))
        else $error("Sprite byte count beyond copy length");

    // A pending sprite write belongs to an active copy.
    a_write_due_active : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.sprite_write_due |-> state_reg.sprite_active)
        else $error("Sprite write due without an active copy");

    // A stalled CPU always comes with a busy DMA unit.
    a_stall_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> m_axis_tdata[27])
        else $error("CPU held without DMA activity");

endmodule
